// File: src/ksa_pkg.sv
// shared types, codes and defaults for the key to slot assignment table
`default_nettype none

package ksa_pkg;

  // default configuration
  localparam int DEF_NUM_TYPES    = 2;
  localparam int DEF_NUM_CHANNELS = 8;
  localparam int DEF_NUM_RATES    = 8;
  localparam int DEF_TABLE_DEPTH  = 32;

  // fixed field widths
  localparam int FUNC_W     = 2;
  localparam int KEY_W      = 8;
  localparam int STAT_W     = 2;
  localparam int SLOT_OUT_W = 5;
  // slot number inside the table; the user must keep the depth within 255, which the code does not enforce
  localparam int SLOT_IDX_W = 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_ASSIGN = 2'd0,
    FN_LOOKUP = 2'd1,
    FN_CHECK  = 2'd2,
    FN_CLEAR  = 2'd3
  } ksa_func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } ksa_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FIN
  } ksa_state_t;

  // search token that walks down the row of cells
  typedef struct packed {
    logic                  vld;
    logic [KEY_W-1:0]      id;
    logic                  hit;
    logic [SLOT_IDX_W-1:0] slot;
  } search_pkt_t;

  // write of one slot, seen by every cell
  typedef struct packed {
    logic                  en;
    logic [SLOT_IDX_W-1:0] addr;
    logic [KEY_W-1:0]      data;
  } slot_wr_t;

endpackage

`default_nettype wire

// File: src/key_to_slot_assign_lookup_table_core.sv
// top level of the key to slot assignment table: controller and row of slot cells
//
//   channel | dir | tdata fields (lsb first)                        | width
//   in_     | in  | func, key_type, key_channel, key_rate           | 32
//   out_    | out | status, slot, key_in_range, present             | 16
//
// every request passes through the row of cells and then the finish state:
// the search token steps through one slot cell per cycle, then the finish
// state settles the result and table update once the result register is free
// one request is in flight at a time; in_tready is high only while idle
// the result register frees the search side, so a new request can be taken
// while the previous result still waits on out_tready
// synchronous active-low reset empties the table (fill count to zero); the
// stored ids themselves are not cleared
`default_nettype none

module key_to_slot_assign_lookup_table_core #(
  parameter int NUM_TYPES    = ksa_pkg::DEF_NUM_TYPES,
  parameter int NUM_CHANNELS = ksa_pkg::DEF_NUM_CHANNELS,
  parameter int NUM_RATES    = ksa_pkg::DEF_NUM_RATES,
  parameter int TABLE_DEPTH  = ksa_pkg::DEF_TABLE_DEPTH
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [31:0] in_tdata,   // func[1:0], key_type[9:2], key_channel[17:10],
                                 // key_rate[25:18], zero fill
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [15:0] out_tdata  // status[1:0], slot[6:2], key_in_range[7],
                                 // present[8], zero fill
);
  import ksa_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // request fields
  logic [FUNC_W-1:0] in_func;
  logic [KEY_W-1:0]  in_type;
  logic [KEY_W-1:0]  in_chan;
  logic [KEY_W-1:0]  in_rate;
  assign in_func = in_tdata[1:0];
  assign in_type = in_tdata[9:2];
  assign in_chan = in_tdata[17:10];
  assign in_rate = in_tdata[25:18];

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // range check and flattening of the key
  logic        key_ok;
  logic [15:0] id_wide;
  assign key_ok = (in_type < KEY_W'(NUM_TYPES)) && (in_chan < KEY_W'(NUM_CHANNELS)) &&
                  (in_rate < KEY_W'(NUM_RATES));
  assign id_wide = 16'(in_type) * 16'(NUM_CHANNELS * NUM_RATES) +
                   16'(in_chan) * 16'(NUM_RATES) + 16'(in_rate);

  // held request
  ksa_state_t            state_r, state_nxt;
  ksa_func_t             func_r;
  logic                  ok_r;
  logic [KEY_W-1:0]      id_r;
  logic                  hit_r;
  logic [SLOT_IDX_W-1:0] hit_slot_r;
  logic [CNT_W-1:0]      used_cnt_r, used_cnt_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]     res_status_r, res_status_nxt;
  logic [SLOT_OUT_W-1:0] res_slot_r, res_slot_nxt;
  logic                  res_range_r, res_range_nxt;
  logic                  res_present_r, res_present_nxt;

  // the row of cells
  search_pkt_t chain [TABLE_DEPTH+1];
  slot_wr_t    wr;

  assign chain[0].vld  = in_acc;
  assign chain[0].id   = id_wide[KEY_W-1:0];
  assign chain[0].hit  = 1'b0;
  assign chain[0].slot = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    ksa_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .used_cnt (used_cnt_r),
      .wr       (wr),
      .pkt_i    (chain[g]),
      .pkt_o    (chain[g+1])
    );
  end

  search_pkt_t tail;
  assign tail = chain[TABLE_DEPTH];

  logic fin_go;
  assign fin_go = (state_r == S_FIN) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt       = state_r;
    used_cnt_nxt    = used_cnt_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    res_status_nxt  = res_status_r;
    res_slot_nxt    = res_slot_r;
    res_range_nxt   = res_range_r;
    res_present_nxt = res_present_r;
    wr.en           = 1'b0;
    wr.addr         = SLOT_IDX_W'(used_cnt_r);
    wr.data         = id_r;
    in_tready       = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (tail.vld) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt       = S_IDLE;
          out_valid_nxt   = 1'b1;
          res_status_nxt  = ST_OK;
          res_slot_nxt    = '0;
          res_range_nxt   = ok_r;
          res_present_nxt = ok_r && hit_r;
          unique case (func_r)
            FN_ASSIGN: begin
              if (!ok_r) begin
                res_status_nxt = ST_RANGE;
              end else if (used_cnt_r == CNT_W'(TABLE_DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                res_slot_nxt = wr.addr[SLOT_OUT_W-1:0];
                wr.en        = 1'b1;
                used_cnt_nxt = used_cnt_r + CNT_W'(1);
              end
            end
            FN_LOOKUP: begin
              if (!ok_r) begin
                res_status_nxt = ST_RANGE;
              end else if (!hit_r) begin
                res_status_nxt = ST_MISSING;
              end else begin
                res_slot_nxt = hit_slot_r[SLOT_OUT_W-1:0];
              end
            end
            FN_CHECK: begin
              res_status_nxt = ok_r ? ST_OK : ST_RANGE;
            end
            FN_CLEAR: begin
              used_cnt_nxt = '0;
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_cnt_r  <= used_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= ksa_func_t'(in_func);
      ok_r   <= key_ok;
      id_r   <= id_wide[KEY_W-1:0];
    end
    if ((state_r == S_SEARCH) && tail.vld) begin
      hit_r      <= tail.hit;
      hit_slot_r <= tail.slot;
    end
    res_status_r  <= res_status_nxt;
    res_slot_r    <= res_slot_nxt;
    res_range_r   <= res_range_nxt;
    res_present_r <= res_present_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_present_r, res_range_r, res_slot_r, res_status_r};

endmodule

`default_nettype wire

// File: src/ksa_cell.sv
// one table slot: holds a stored id and checks the passing search token
`default_nettype none

module ksa_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire [CNT_W-1:0]      used_cnt,
  input  ksa_pkg::slot_wr_t    wr,
  input  ksa_pkg::search_pkt_t pkt_i,
  output ksa_pkg::search_pkt_t pkt_o
);
  import ksa_pkg::*;

  logic [KEY_W-1:0] key_r;
  search_pkt_t      pkt_r;
  search_pkt_t      pkt_nxt;
  logic             match;

  // only slots below the fill count take part
  assign match = pkt_i.vld && !pkt_i.hit && (CNT_W'(IDX) < used_cnt) &&
                 (key_r == pkt_i.id);

  always_comb begin
    pkt_nxt = pkt_i;
    if (match) begin
      pkt_nxt.hit  = 1'b1;
      pkt_nxt.slot = SLOT_IDX_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == SLOT_IDX_W'(IDX))) begin
      key_r <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r.vld <= 1'b0;
    end else begin
      pkt_r.vld <= pkt_nxt.vld;
    end
    pkt_r.id   <= pkt_nxt.id;
    pkt_r.hit  <= pkt_nxt.hit;
    pkt_r.slot <= pkt_nxt.slot;
  end

  assign pkt_o = pkt_r;

endmodule

`default_nettype wire

// File: src/ksa_checker.sv
// port-level checks for the key to slot assignment table, bound to the top level
`default_nettype none

module ksa_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire [31:0] in_tdata,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [15:0] out_tdata
);
  import ksa_pkg::*;

  // a waiting request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("request changed while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one request in flight: no request taken right after another
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // slot is zero unless the status is ok
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != ST_OK) |-> (out_tdata[6:2] == '0))
    else $error("slot set on failing status");

  // a present key is always in range
  a_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> out_tdata[7])
    else $error("present without key in range");

endmodule

bind key_to_slot_assign_lookup_table_core ksa_checker u_ksa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
